FILE: src/sot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sot_pkg;
    localparam int MAX_OBSTACLES = 256;
    localparam int COORD_BITS    = 24;
    localparam int ADDR_W        = $clog2(MAX_OBSTACLES);
    localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);
    localparam int ROW_W         = 9 * COORD_BITS;
    localparam int WIDE_W        = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int ORI_W         = PROD_W + 1;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [WIDE_W-1:0]     t_wide;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [ORI_W-1:0]      t_ori;
    typedef logic [ROW_W-1:0]             t_row;

    localparam t_wide COORD_TOL  = t_wide'(3);
    localparam t_ori  ORI_TOL_P  = t_ori'(655);
    localparam t_ori  ORI_TOL_N  = -ORI_TOL_P;

    typedef struct packed {
        t_coord sx;
        t_coord sz;
        t_coord ex;
        t_coord ez;
        t_diff  dex;
        t_diff  dez;
        t_wide  blx;
        t_wide  bhx;
        t_wide  bly;
        t_wide  bhy;
        t_wide  blz;
        t_wide  bhz;
        t_wide  tlx;
        t_wide  thx;
        t_wide  tlz;
        t_wide  thz;
    } t_seg;

    typedef struct packed {
        logic       valid;
        logic [1:0] k_sel;
    } t_edge_ctl;

    function automatic t_wide wx(input t_coord c);
        return t_wide'(c);
    endfunction

    function automatic t_diff dif(input t_coord a, input t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

    function automatic t_wide mn(input t_wide a, input t_wide b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_wide mx(input t_wide a, input t_wide b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_coord get_c(input t_row row, input int idx);
        return t_coord'(row[idx*COORD_BITS +: COORD_BITS]);
    endfunction
endpackage
`default_nettype wire

FILE: src/sot_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sot_in_if import sot_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    t_coord     a_x;
    t_coord     a_y;
    t_coord     a_z;
    t_coord     b_x;
    t_coord     b_y;
    t_coord     b_z;
    t_coord     c_x;
    t_coord     c_y;
    t_coord     c_z;
    modport source (output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                    input ready);
    modport sink (input valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  output ready);
endinterface
`default_nettype wire

FILE: src/sot_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sot_out_if import sot_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             blocked;
    logic [CNT_W-1:0] stored_count;
    logic             overflow;
    modport source (output valid, blocked, stored_count, overflow, input ready);
    modport sink (input valid, blocked, stored_count, overflow, output ready);
endinterface
`default_nettype wire

FILE: src/sot_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sot_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [15:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

FILE: src/segment_obstacle_test_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Obstacle triangle store with a segment-blocking query. Clear and load items give their
// result beat in the next cycle; a load into a full store is dropped and reports
// overflow. A query reads each stored triangle once from the triangle RAM and tests one
// edge per cycle through a three-stage orientation pipeline. The RAM needs no clearing
// after reset: only rows below the stored count are read. One item is in work at a
// time; the next is taken once the previous result beat has been taken or is taken
// in the same cycle.
module segment_obstacle_test_core import sot_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sot_in_if.sink    i_in,
    sot_out_if.source o_out,
    sot_cfg_if.sink   i_cfg
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} t_state;

    t_state           r_state;
    logic [15:0]      r_radius, r_height;
    logic [CNT_W-1:0] r_count;
    logic [ADDR_W-1:0] r_idx;
    logic [1:0]       r_k;
    logic [1:0]       r_drain;
    logic             r_acc;
    t_seg             r_seg;
    logic             r_out_valid, r_out_blocked, r_out_ovf;
    logic [CNT_W-1:0] r_out_count;

    logic             in_acc, out_free, full, last_tri;
    logic             ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    t_row             ram_wdata, ram_rdata;
    t_edge_ctl        edge_ctl;
    logic             hit_valid, hit;
    t_seg             n_seg;
    t_wide            rad_w, hgt_w, smn_x, smx_x, smn_z, smx_z;

    assign out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_acc    = i_in.valid && i_in.ready;
    assign full      = r_count == CNT_W'(MAX_OBSTACLES);
    assign last_tri  = (CNT_W'(r_idx) + CNT_W'(1)) >= r_count;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        rad_w = t_wide'({1'b0, r_radius});
        hgt_w = t_wide'({1'b0, r_height});
        smn_x = mn(wx(i_in.a_x), wx(i_in.b_x));
        smx_x = mx(wx(i_in.a_x), wx(i_in.b_x));
        smn_z = mn(wx(i_in.a_z), wx(i_in.b_z));
        smx_z = mx(wx(i_in.a_z), wx(i_in.b_z));
        n_seg.sx  = i_in.a_x;
        n_seg.sz  = i_in.a_z;
        n_seg.ex  = i_in.b_x;
        n_seg.ez  = i_in.b_z;
        n_seg.dex = dif(i_in.b_x, i_in.a_x);
        n_seg.dez = dif(i_in.b_z, i_in.a_z);
        n_seg.blx = smn_x - rad_w;
        n_seg.bhx = smx_x + rad_w;
        n_seg.bly = mn(wx(i_in.a_y), wx(i_in.b_y));
        n_seg.bhy = mx(wx(i_in.a_y), wx(i_in.b_y)) + hgt_w;
        n_seg.blz = smn_z - rad_w;
        n_seg.bhz = smx_z + rad_w;
        n_seg.tlx = smn_x - COORD_TOL;
        n_seg.thx = smx_x + COORD_TOL;
        n_seg.tlz = smn_z - COORD_TOL;
        n_seg.thz = smx_z + COORD_TOL;
    end

    always_comb begin
        ram_we    = in_acc && i_in.cmd == CMD_LOAD && !full;
        ram_wdata = {i_in.c_z, i_in.c_y, i_in.c_x, i_in.b_z, i_in.b_y, i_in.b_x,
                     i_in.a_z, i_in.a_y, i_in.a_x};
        ram_re    = 1'b0;
        ram_addr  = r_count[ADDR_W-1:0];
        if (in_acc && i_in.cmd == CMD_QUERY) begin
            ram_re   = 1'b1;
            ram_addr = '0;
        end else if (r_state == S_RUN && r_k == 2'd2 && !last_tri) begin
            // fetch the next row so it lands for its first edge
            ram_re   = 1'b1;
            ram_addr = r_idx + ADDR_W'(1);
        end
        edge_ctl.valid = r_state == S_RUN;
        edge_ctl.k_sel = r_k;
    end

    sot_ram #(.WIDTH(ROW_W), .DEPTH(MAX_OBSTACLES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    sot_edge_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (edge_ctl),
        .i_row       (ram_rdata),
        .i_seg       (r_seg),
        .o_hit_valid (hit_valid),
        .o_hit       (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radius    <= '0;
            r_height    <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_k         <= '0;
            r_drain     <= '0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.addr)
                    REG_RADIUS: r_radius <= i_cfg.data;
                    REG_HEIGHT: r_height <= i_cfg.data;
                    default: ;
                endcase
            end
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (hit_valid && hit) begin
                r_acc <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_out_blocked <= 1'b0;
                        r_out_ovf     <= 1'b0;
                        r_out_count   <= r_count;
                        unique case (i_in.cmd)
                            CMD_CLEAR: begin
                                r_count     <= '0;
                                r_out_count <= '0;
                                r_out_valid <= 1'b1;
                            end
                            CMD_LOAD: begin
                                if (full) begin
                                    r_out_ovf <= 1'b1;
                                end else begin
                                    r_count     <= r_count + CNT_W'(1);
                                    r_out_count <= r_count + CNT_W'(1);
                                end
                                r_out_valid <= 1'b1;
                            end
                            CMD_QUERY: begin
                                r_seg   <= n_seg;
                                r_idx   <= '0;
                                r_k     <= '0;
                                r_acc   <= 1'b0;
                                r_drain <= 2'd3;
                                r_state <= (r_count == '0) ? S_DONE : S_RUN;
                            end
                            default: r_out_valid <= 1'b1;
                        endcase
                    end
                end
                S_RUN: begin
                    if (r_k == 2'd2) begin
                        r_k <= '0;
                        if (last_tri) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_idx <= r_idx + ADDR_W'(1);
                        end
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_DRAIN: begin
                    // hold until the last edge has left the pipe
                    r_drain <= r_drain - 2'd1;
                    if (r_drain == 2'd0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_blocked <= r_acc;
                        r_out_ovf     <= 1'b0;
                        r_out_count   <= r_count;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.blocked      = r_out_blocked;
    assign o_out.stored_count = r_out_count;
    assign o_out.overflow     = r_out_ovf;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_OBSTACLES))
        else $error("stored count beyond capacity");

    a_run_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> CNT_W'(r_idx) < r_count)
        else $error("row index past stored count");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.cmd == CMD_LOAD && full |=> $stable(r_count) && r_out_ovf)
        else $error("load into full store changed the store");

    a_no_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !edge_ctl.valid)
        else $error("edge issued outside a query");
endmodule
`default_nettype wire

FILE: src/sot_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: src/sot_edge_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
module sot_edge_pipe import sot_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_edge_ctl i_ctl,
    input  wire t_row      i_row,
    input  wire t_seg      i_seg,
    output logic           o_hit_valid,
    output logic           o_hit
);
    t_coord vx [3];
    t_coord vy [3];
    t_coord vz [3];
    t_coord q0x, q0y, q0z, q1x, q1y, q1z;
    logic   box_ok, hgt_ok, q0_in, q1_in, s_in, e_in;
    t_wide  ex_lo, ex_hi, ez_lo, ez_hi;

    // stage 1
    logic  r_s1_vld, r_s1_en, r_s1_q0in, r_s1_q1in, r_s1_sin, r_s1_ein;
    t_diff r_a1, r_a2, r_b1, r_b2, r_e1, r_e2, r_e3, r_e4, r_f1, r_f2;
    t_diff r_dex, r_dez;
    // stage 2
    logic  r_s2_vld, r_s2_en, r_s2_q0in, r_s2_q1in, r_s2_sin, r_s2_ein;
    t_prod r_p0a, r_p0b, r_p1a, r_p1b, r_p2a, r_p2b, r_p3a, r_p3b;
    // stage 3
    logic  r_hit_vld, r_hit;
    t_ori  o0, o1, o2, o3;
    logic  sm0, sm1, sm2, sm3, xing, n_hit;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            vx[v] = get_c(i_row, 3*v);
            vy[v] = get_c(i_row, 3*v + 1);
            vz[v] = get_c(i_row, 3*v + 2);
        end
        unique case (i_ctl.k_sel)
            2'd0: begin
                q0x = vx[0]; q0y = vy[0]; q0z = vz[0];
                q1x = vx[1]; q1y = vy[1]; q1z = vz[1];
            end
            2'd1: begin
                q0x = vx[1]; q0y = vy[1]; q0z = vz[1];
                q1x = vx[2]; q1y = vy[2]; q1z = vz[2];
            end
            default: begin
                q0x = vx[2]; q0y = vy[2]; q0z = vz[2];
                q1x = vx[0]; q1y = vy[0]; q1z = vz[0];
            end
        endcase
        box_ok = i_seg.bhx >= mn(wx(vx[0]), mn(wx(vx[1]), wx(vx[2]))) &&
                 i_seg.blx <= mx(wx(vx[0]), mx(wx(vx[1]), wx(vx[2]))) &&
                 i_seg.bhy >= mn(wx(vy[0]), mn(wx(vy[1]), wx(vy[2]))) &&
                 i_seg.bly <= mx(wx(vy[0]), mx(wx(vy[1]), wx(vy[2]))) &&
                 i_seg.bhz >= mn(wx(vz[0]), mn(wx(vz[1]), wx(vz[2]))) &&
                 i_seg.blz <= mx(wx(vz[0]), mx(wx(vz[1]), wx(vz[2])));
        hgt_ok = i_seg.bhy >= mn(wx(q0y), wx(q1y)) && i_seg.bly <= mx(wx(q0y), wx(q1y));
        q0_in  = wx(q0x) >= i_seg.tlx && wx(q0x) <= i_seg.thx &&
                 wx(q0z) >= i_seg.tlz && wx(q0z) <= i_seg.thz;
        q1_in  = wx(q1x) >= i_seg.tlx && wx(q1x) <= i_seg.thx &&
                 wx(q1z) >= i_seg.tlz && wx(q1z) <= i_seg.thz;
        ex_lo  = mn(wx(q0x), wx(q1x)) - COORD_TOL;
        ex_hi  = mx(wx(q0x), wx(q1x)) + COORD_TOL;
        ez_lo  = mn(wx(q0z), wx(q1z)) - COORD_TOL;
        ez_hi  = mx(wx(q0z), wx(q1z)) + COORD_TOL;
        s_in   = wx(i_seg.sx) >= ex_lo && wx(i_seg.sx) <= ex_hi &&
                 wx(i_seg.sz) >= ez_lo && wx(i_seg.sz) <= ez_hi;
        e_in   = wx(i_seg.ex) >= ex_lo && wx(i_seg.ex) <= ex_hi &&
                 wx(i_seg.ez) >= ez_lo && wx(i_seg.ez) <= ez_hi;
    end

    always_comb begin
        o0 = t_ori'(r_p0a) - t_ori'(r_p0b);
        o1 = t_ori'(r_p1a) - t_ori'(r_p1b);
        o2 = t_ori'(r_p2a) - t_ori'(r_p2b);
        o3 = t_ori'(r_p3a) - t_ori'(r_p3b);
        sm0 = o0 <= ORI_TOL_P && o0 >= ORI_TOL_N;
        sm1 = o1 <= ORI_TOL_P && o1 >= ORI_TOL_N;
        sm2 = o2 <= ORI_TOL_P && o2 >= ORI_TOL_N;
        sm3 = o3 <= ORI_TOL_P && o3 >= ORI_TOL_N;
        xing = ((o0 > 0 && o1 < 0) || (o0 < 0 && o1 > 0)) &&
               ((o2 > 0 && o3 < 0) || (o2 < 0 && o3 > 0));
        n_hit = r_s2_en && (xing || (sm0 && r_s2_q0in) || (sm1 && r_s2_q1in) ||
                                    (sm2 && r_s2_sin) || (sm3 && r_s2_ein));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_hit_vld <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_s1_vld  <= i_ctl.valid;
            r_s2_vld  <= r_s1_vld;
            r_hit_vld <= r_s2_vld;
            r_hit     <= n_hit;
        end
        r_s1_en    <= i_ctl.valid && box_ok && hgt_ok;
        r_s1_q0in  <= q0_in;
        r_s1_q1in  <= q1_in;
        r_s1_sin   <= s_in;
        r_s1_ein   <= e_in;
        r_dex      <= i_seg.dex;
        r_dez      <= i_seg.dez;
        r_a1       <= dif(q0z, i_seg.sz);
        r_a2       <= dif(q0x, i_seg.sx);
        r_b1       <= dif(q1z, i_seg.sz);
        r_b2       <= dif(q1x, i_seg.sx);
        r_e1       <= dif(q1x, q0x);
        r_e2       <= dif(i_seg.sz, q0z);
        r_e3       <= dif(q1z, q0z);
        r_e4       <= dif(i_seg.sx, q0x);
        r_f1       <= dif(i_seg.ez, q0z);
        r_f2       <= dif(i_seg.ex, q0x);
        r_s2_en    <= r_s1_vld && r_s1_en;
        r_s2_q0in  <= r_s1_q0in;
        r_s2_q1in  <= r_s1_q1in;
        r_s2_sin   <= r_s1_sin;
        r_s2_ein   <= r_s1_ein;
        r_p0a      <= r_dex * r_a1;
        r_p0b      <= r_dez * r_a2;
        r_p1a      <= r_dex * r_b1;
        r_p1b      <= r_dez * r_b2;
        r_p2a      <= r_e1 * r_e2;
        r_p2b      <= r_e3 * r_e4;
        r_p3a      <= r_e1 * r_f1;
        r_p3b      <= r_e3 * r_f2;
    end

    assign o_hit_valid = r_hit_vld;
    assign o_hit       = r_hit;
endmodule
`default_nettype wire
